/* hdl/spq_pkg.sv */
// Shared constants and control/status types for the stable priority queue.
package spq_pkg;

	localparam int DEF_CAPACITY = 256;

	localparam int KIND_W   = 2;
	localparam int SEV_W    = 16;
	localparam int TAG_W    = 16;
	localparam int STAMP_W  = 32;
	localparam int STATUS_W = 3;
	localparam int OCC_W    = 9;

	// stream word widths, padded to whole bytes
	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 48;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_SERVE  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_RSVD   = 2'd3;  // decoded as clear

	localparam logic [STATUS_W-1:0] STATUS_INSERTED = 3'd0;
	localparam logic [STATUS_W-1:0] STATUS_SERVED   = 3'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
	localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd3;
	localparam logic [STATUS_W-1:0] STATUS_CLEARED  = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic latch;      // capture input word
		logic scan_init;  // reset best-entry tracking
		logic scan_rd;    // read next slot
		logic finish;     // apply update and load result
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_serve;
		logic empty;
		logic scan_last;  // slot being read is the last occupied one
		logic out_free;   // result register can take a new word
	} stat_t;

endpackage

/* hdl/spq_ctrl.sv */
// Sequencer for the stable priority queue: decode, slot scan, commit.
module spq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  spq_pkg::stat_t    stat,
	output spq_pkg::cmd_t     cmd
);

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECODE = 5'b00010,
		ST_SCAN   = 5'b00100,
		ST_DRAIN  = 5'b01000,
		ST_FIN    = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.latch = 1'b1;
					state_d   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				if (stat.is_serve && !stat.empty) begin
					cmd.scan_init = 1'b1;
					state_d       = ST_SCAN;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_SCAN: begin
				cmd.scan_rd = 1'b1;
				if (stat.scan_last) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				// last read word is compared this cycle
				state_d = ST_FIN;
			end
			ST_FIN: begin
				if (stat.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

/* hdl/spq_dp.sv */
// Datapath: entry store, occupancy and arrival counters, best-entry scan, result register.
module spq_dp #(
	parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,
	input  logic [spq_pkg::KIND_W-1:0]      s_tuser,
	input  spq_pkg::cmd_t                   cmd,
	output spq_pkg::stat_t                  stat,
	input  logic                            m_tready,
	output logic                            m_tvalid,
	output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,
	output logic [spq_pkg::STATUS_W-1:0]    m_tuser
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef struct packed {
		logic [spq_pkg::STAMP_W-1:0] stamp;
		logic [spq_pkg::TAG_W-1:0]   tag;
		logic [spq_pkg::SEV_W-1:0]   sev;
	} entry_t;

	entry_t mem [CAPACITY];

	// item payload
	logic [spq_pkg::KIND_W-1:0]  kind_q;
	logic [spq_pkg::SEV_W-1:0]   sev_q;
	logic [spq_pkg::TAG_W-1:0]   tag_q;

	logic [CW-1:0]               count_q, count_d;
	logic [spq_pkg::STAMP_W-1:0] stamp_ctr_q, stamp_ctr_d;

	// scan
	logic [AW-1:0] idx_q;
	logic          rd_vld_s1;
	logic [AW-1:0] rd_idx_s1;
	entry_t        rd_data_s1;
	entry_t        best_q;
	logic [AW-1:0] best_idx_q;
	logic          best_vld_q;
	entry_t        last_q;
	logic          cand_wins;

	// store write port
	logic          mem_we;
	logic [AW-1:0] mem_waddr;
	entry_t        mem_wdata;

	// result register
	logic                         out_vld_q;
	logic [spq_pkg::STATUS_W-1:0] status_q, status_d;
	logic [spq_pkg::TAG_W-1:0]    otag_q, otag_d;
	logic [spq_pkg::SEV_W-1:0]    osev_q, osev_d;
	logic [spq_pkg::OCC_W-1:0]    occ_q;

	logic is_serve, is_insert, is_clear, empty, full;

	assign is_serve  = (kind_q == spq_pkg::KIND_SERVE);
	assign is_insert = (kind_q == spq_pkg::KIND_INSERT);
	assign is_clear  = kind_q inside {spq_pkg::KIND_CLEAR, spq_pkg::KIND_RSVD};
	assign empty     = (count_q == '0);
	assign full      = (count_q >= CW'(CAPACITY));

	assign stat.is_serve  = is_serve;
	assign stat.empty     = empty;
	assign stat.scan_last = (CW'(idx_q) == count_q - CW'(1));
	assign stat.out_free  = !out_vld_q || m_tready;

	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			kind_q <= s_tuser;
			sev_q  <= s_tdata[spq_pkg::SEV_W-1:0];
			tag_q  <= s_tdata[spq_pkg::SEV_W +: spq_pkg::TAG_W];
		end
	end

	// store: one write, one registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (cmd.scan_rd) begin
			rd_data_s1 <= mem[idx_q];
		end
	end

	// higher severity wins; equal severity goes to the older stamp; full tie keeps lower slot
	assign cand_wins = !best_vld_q
		|| (rd_data_s1.sev > best_q.sev)
		|| ((rd_data_s1.sev == best_q.sev) && (rd_data_s1.stamp < best_q.stamp));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1  <= 1'b0;
			best_vld_q <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.scan_rd;
			if (cmd.scan_init) begin
				best_vld_q <= 1'b0;
			end else if (rd_vld_s1) begin
				best_vld_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			idx_q <= '0;
		end else if (cmd.scan_rd) begin
			idx_q <= idx_q + AW'(1);
		end
		if (cmd.scan_rd) begin
			rd_idx_s1 <= idx_q;
		end
		if (rd_vld_s1 && cand_wins) begin
			best_q     <= rd_data_s1;
			best_idx_q <= rd_idx_s1;
		end
		// keep the top entry to refill the served slot
		if (rd_vld_s1 && (CW'(rd_idx_s1) == count_q - CW'(1))) begin
			last_q <= rd_data_s1;
		end
	end

	always_comb begin
		count_d     = count_q;
		stamp_ctr_d = stamp_ctr_q;
		status_d    = spq_pkg::STATUS_EMPTY;
		otag_d      = '0;
		osev_d      = '0;
		mem_we      = 1'b0;
		mem_waddr   = count_q[AW-1:0];
		mem_wdata   = '{stamp: stamp_ctr_q, tag: tag_q, sev: sev_q};
		if (is_clear) begin
			count_d     = '0;
			stamp_ctr_d = '0;
			status_d    = spq_pkg::STATUS_CLEARED;
		end else if (is_insert) begin
			if (full) begin
				status_d = spq_pkg::STATUS_FULL;
			end else begin
				mem_we      = cmd.finish;
				count_d     = count_q + CW'(1);
				stamp_ctr_d = stamp_ctr_q + spq_pkg::STAMP_W'(1);
				status_d    = spq_pkg::STATUS_INSERTED;
			end
		end else if (!empty) begin
			mem_we    = cmd.finish;
			mem_waddr = best_idx_q;
			mem_wdata = last_q;
			count_d   = count_q - CW'(1);
			otag_d    = best_q.tag;
			osev_d    = best_q.sev;
			status_d  = spq_pkg::STATUS_SERVED;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			stamp_ctr_q <= '0;
			out_vld_q   <= 1'b0;
		end else begin
			if (cmd.finish) begin
				count_q     <= count_d;
				stamp_ctr_q <= stamp_ctr_d;
				out_vld_q   <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			status_q <= status_d;
			otag_q   <= otag_d;
			osev_q   <= osev_d;
			occ_q    <= spq_pkg::OCC_W'(count_d);
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tuser  = status_q;
	assign m_tdata  = spq_pkg::M_TDATA_W'({occ_q, osev_q, otag_q});

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_rd |-> (CW'(idx_q) < count_q))
		else $error("scan read beyond occupied slots");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("occupancy above capacity");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_vld_q || m_tready))
		else $error("result register overwritten while held");

	a_serve_drops_one: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.finish && is_serve && !empty) |=> (count_q == $past(count_q) - CW'(1)))
		else $error("serve did not remove exactly one entry");

endmodule

/* hdl/stable_priority_queue.sv */
// Top level of the stable max-priority queue with first-in-first-out tie-break.
//
// Usage:
//   Input stream (s_*): one word per command. s_tuser carries the kind
//   (insert, serve, clear; the unused code acts as clear), s_tdata the
//   severity and tag of an insert. Output stream (m_*): exactly one word per
//   command, with the status in m_tuser and the served tag, served severity
//   and occupancy after the command in m_tdata.
//   A serve returns the highest severity held; among equal severities the
//   earliest inserted. Full inserts and empty serves are reported, not done.
// Sequence:
//   Insert, clear and empty serve: the word is latched when accepted, then
//   decoded and committed; the next word is accepted only after the commit.
//   Serve of a queue holding N entries: one store read per cycle over all N
//   slots, then a drain state for the last compare, then the commit.
//   The single read port of the entry store sets the serve time.
// Reset: arst_n empties the queue and zeroes the arrival counter; the entry
//   store itself is not cleared and no clearing pass runs.
// Stall: the result sits in an output register; the block takes the next word
//   meanwhile and holds its commit until that register is free.
module stable_priority_queue #(
	parameter int CAPACITY = spq_pkg::DEF_CAPACITY
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [spq_pkg::S_TDATA_W-1:0]   s_tdata,   // severity[15:0], tag[31:16]
	input  logic [spq_pkg::KIND_W-1:0]      s_tuser,   // kind[1:0]
	output logic                            m_tvalid,
	input  logic                            m_tready,
	output logic [spq_pkg::M_TDATA_W-1:0]   m_tdata,   // served_tag[15:0], served_severity[31:16],
	                                                   // occupancy[40:32], zero[47:41]
	output logic [spq_pkg::STATUS_W-1:0]    m_tuser    // status[2:0]
);

	spq_pkg::cmd_t  cmd;
	spq_pkg::stat_t stat;

	// sequencer: accept, decode, scan slots, commit
	spq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// store, counters, best-entry compare, result register
	spq_dp #(
		.CAPACITY (CAPACITY)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.cmd      (cmd),
		.stat     (stat),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the stable max-priority queue stream block.
`timescale 1ns / 100ps

module testbench;
	import spq_pkg::*;

	localparam int QCAP        = DEF_CAPACITY;
	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 9;
	localparam int WORD_TARGET = 1300;
	// Worst case: every word a serve over a full queue plus the longest input and
	// output gaps, and two long output holds. Taken 5x over.
	localparam int CYCLE_LIMIT = 2_000_000;
	localparam int LONG_HOLD   = 400;
	localparam int TAIL_CYCLES = 16;
	localparam int PLAN_LEN    = 25;

	typedef struct packed {
		logic [SEV_W-1:0]   sev;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} entry_t;

	typedef struct packed {
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    tag;
		logic [SEV_W-1:0]    sev;
		logic [OCC_W-1:0]    occ;
	} outcome_t;

	// directed row: command word, then a hand-written outcome where typed is set
	typedef struct packed {
		logic [KIND_W-1:0]   kind;
		logic [SEV_W-1:0]    sev;
		logic [TAG_W-1:0]    tag;
		logic                typed;
		logic [STATUS_W-1:0] status;
		logic [TAG_W-1:0]    out_tag;
		logic [SEV_W-1:0]    out_sev;
		logic [OCC_W-1:0]    occ;
	} plan_row_t;

	logic                 clk      = 1'b0;
	logic                 arst_n   = 1'b0;
	logic                 s_tvalid = 1'b0;
	logic                 s_tready;
	logic [S_TDATA_W-1:0] s_tdata  = '0;  // severity[15:0], tag[31:16]
	logic [KIND_W-1:0]    s_tuser  = KIND_INSERT;  // kind[1:0]
	logic                 m_tvalid;
	logic                 m_tready = 1'b0;
	logic [M_TDATA_W-1:0] m_tdata;  // served_tag[15:0], served_severity[31:16],
	                                // occupancy[40:32], zero[47:41]
	logic [STATUS_W-1:0]  m_tuser;  // status[2:0]

	// queue image kept by the predictor
	entry_t             slots [QCAP];
	int                 held;
	logic [STAMP_W-1:0] next_stamp;

	outcome_t expected_words [$];
	int       sent;
	int       errors;
	int       cycles = 0;

	plan_row_t plan [PLAN_LEN] = '{
		// serve and clear right after reset, junk data ignored
		'{KIND_SERVE,  16'hFFFF, 16'hFFFF, 1'b1, STATUS_EMPTY,    16'h0000, 16'h0000, 9'd0},
		'{KIND_CLEAR,  16'hFFFF, 16'hFFFF, 1'b1, STATUS_CLEARED,  16'h0000, 16'h0000, 9'd0},
		'{KIND_INSERT, 16'h0000, 16'h0000, 1'b1, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd1},
		'{KIND_INSERT, 16'hFFFF, 16'hFFFF, 1'b1, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd2},
		'{KIND_INSERT, 16'h1234, 16'h0001, 1'b1, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd3},
		'{KIND_INSERT, 16'hFFFF, 16'h00AA, 1'b1, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd4},
		// top severity tie: earlier arrival first
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b1, STATUS_SERVED,   16'hFFFF, 16'hFFFF, 9'd3},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b1, STATUS_SERVED,   16'h00AA, 16'hFFFF, 9'd2},
		'{KIND_INSERT, 16'h1234, 16'h0002, 1'b1, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd3},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b1, STATUS_SERVED,   16'h0001, 16'h1234, 9'd2},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b1, STATUS_SERVED,   16'h0002, 16'h1234, 9'd1},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b1, STATUS_SERVED,   16'h0000, 16'h0000, 9'd0},
		'{KIND_SERVE,  16'h5A5A, 16'hA5A5, 1'b1, STATUS_EMPTY,    16'h0000, 16'h0000, 9'd0},
		'{KIND_INSERT, 16'h8000, 16'h5555, 1'b1, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd1},
		'{KIND_INSERT, 16'h7FFF, 16'hAAAA, 1'b1, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd2},
		// unused kind code clears a non-empty queue
		'{KIND_RSVD,   16'hFFFF, 16'hFFFF, 1'b1, STATUS_CLEARED,  16'h0000, 16'h0000, 9'd0},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b1, STATUS_EMPTY,    16'h0000, 16'h0000, 9'd0},
		// ties mixed with a higher entry, order after swap-with-last removal
		'{KIND_INSERT, 16'd5,    16'd1,    1'b0, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd0},
		'{KIND_INSERT, 16'd5,    16'd2,    1'b0, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd0},
		'{KIND_INSERT, 16'd9,    16'd3,    1'b0, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd0},
		'{KIND_INSERT, 16'd5,    16'd4,    1'b0, STATUS_INSERTED, 16'h0000, 16'h0000, 9'd0},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b0, STATUS_SERVED,   16'h0000, 16'h0000, 9'd0},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b0, STATUS_SERVED,   16'h0000, 16'h0000, 9'd0},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b0, STATUS_SERVED,   16'h0000, 16'h0000, 9'd0},
		'{KIND_SERVE,  16'h0000, 16'h0000, 1'b0, STATUS_SERVED,   16'h0000, 16'h0000, 9'd0}
	};

	stable_priority_queue #(
		.CAPACITY(QCAP)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("stable_priority_queue: mismatch");
			$finish;
		end
	end

	// Applies one command word to the queue image and returns its outcome.
	function automatic outcome_t queue_step(input logic [KIND_W-1:0] kind,
	                                        input logic [SEV_W-1:0] sev,
	                                        input logic [TAG_W-1:0] tag);
		outcome_t r;
		int       best;
		int       i;
		r = '0;
		if (kind == KIND_CLEAR || kind == KIND_RSVD) begin
			held       = 0;
			next_stamp = '0;
			r.status   = STATUS_CLEARED;
		end else if (kind == KIND_INSERT) begin
			if (held >= QCAP) begin
				r.status = STATUS_FULL;
			end else begin
				slots[held].sev   = sev;
				slots[held].tag   = tag;
				slots[held].stamp = next_stamp;
				held++;
				next_stamp = next_stamp + STAMP_W'(1);
				r.status   = STATUS_INSERTED;
			end
		end else begin
			if (held == 0) begin
				r.status = STATUS_EMPTY;
			end else begin
				best = 0;
				// higher severity wins, then smaller stamp, then lower slot
				for (i = 1; i < held; i++) begin
					if (slots[i].sev > slots[best].sev ||
					    (slots[i].sev == slots[best].sev &&
					     slots[i].stamp < slots[best].stamp))
						best = i;
				end
				r.tag       = slots[best].tag;
				r.sev       = slots[best].sev;
				held--;
				slots[best] = slots[held];
				r.status    = STATUS_SERVED;
			end
		end
		r.occ = OCC_W'(held);
		return r;
	endfunction

	// idle cycles before a word; every fifth run of 48 words has none
	function automatic int draw_gap(input int n);
		if ((n / 48) % 5 == 2)
			return 0;
		return $urandom_range(0, 12);
	endfunction

	// severity flavor: narrow (many ties), extremes, or full range
	function automatic logic [SEV_W-1:0] pick_severity(input int mode);
		logic [SEV_W-1:0] corner [4];
		corner = '{16'h0000, 16'hFFFF, 16'h7FFF, 16'h8000};
		case (mode)
			0: return SEV_W'($urandom_range(0, 3));
			1: return corner[$urandom_range(0, 3)];
			default: return SEV_W'($urandom);
		endcase
	endfunction

	// Offers one word, waits for it to be taken, and records its outcome.
	task automatic send_word(input logic [KIND_W-1:0] kind, input logic [SEV_W-1:0] sev,
	                         input logic [TAG_W-1:0] tag, input logic typed,
	                         input outcome_t typed_outcome);
		int       gap;
		outcome_t calc;
		gap = draw_gap(sent);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {tag, sev};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		calc = queue_step(kind, sev, tag);
		expected_words.push_back(typed ? typed_outcome : calc);
		sent++;
	endtask

	task automatic send_random(input logic [KIND_W-1:0] kind, input int mode);
		send_word(kind, pick_severity(mode), TAG_W'($urandom), 1'b0, '0);
	endtask

	task automatic report(input string field, input logic [31:0] want, input logic [31:0] got);
		errors++;
		$display("%0t: %s expected %0h got %0h", $time, field, want, got);
	endtask

	// stimulus and end of run
	initial begin : source
		int               r;
		int               n;
		int               mode;
		int               seg;
		int               pick;
		outcome_t         row_out;
		logic [KIND_W-1:0] k;
		held       = 0;
		next_stamp = '0;
		sent       = 0;
		errors     = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			row_out.status = plan[i].status;
			row_out.tag    = plan[i].out_tag;
			row_out.sev    = plan[i].out_sev;
			row_out.occ    = plan[i].occ;
			send_word(plan[i].kind, plan[i].sev, plan[i].tag, plan[i].typed, row_out);
		end

		// random runs: fill to full and beyond, drain to empty and beyond, or a mix
		seg = 0;
		while (sent < WORD_TARGET) begin
			r    = $urandom_range(0, 11);
			mode = $urandom_range(0, 2);
			if (seg == 0 || r == 0) begin
				while (held < QCAP && sent < WORD_TARGET) send_random(KIND_INSERT, mode);
				repeat ($urandom_range(1, 3)) begin
					if (sent < WORD_TARGET)
						send_random(KIND_INSERT, mode);
				end
			end else if (r == 1) begin
				while (held > 0 && sent < WORD_TARGET) send_random(KIND_SERVE, mode);
				if (sent < WORD_TARGET)
					send_random(KIND_SERVE, mode);
			end else begin
				n = $urandom_range(20, 80);
				repeat (n) begin
					if (sent < WORD_TARGET) begin
						pick = $urandom_range(0, 99);
						if (pick < 55)
							k = KIND_INSERT;
						else if (pick < 93)
							k = KIND_SERVE;
						else if (pick < 97)
							k = KIND_CLEAR;
						else
							k = KIND_RSVD;
						send_random(k, mode);
					end
				end
			end
			seg++;
		end
		s_tvalid <= 1'b0;

		while (expected_words.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("stable_priority_queue: match");
		else
			$display("stable_priority_queue: mismatch");
		$finish;
	end

	// result side: random stalls, two long holds to back the block up
	initial begin : sink
		int       gap;
		int       got;
		outcome_t want;
		got = 0;
		@(posedge arst_n);
		forever begin
			gap = draw_gap(got);
			if (got == 350 || got == 1000)
				gap = LONG_HOLD;
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
			if (expected_words.size() == 0) begin
				errors++;
				$display("%0t: unexpected word, expected none got %0h/%0h",
				         $time, m_tuser, m_tdata);
			end else begin
				want = expected_words.pop_front();
				if (m_tuser !== want.status)
					report("status", 32'(want.status), 32'(m_tuser));
				if (m_tdata[15:0] !== want.tag)
					report("served_tag", 32'(want.tag), 32'(m_tdata[15:0]));
				if (m_tdata[31:16] !== want.sev)
					report("served_severity", 32'(want.sev), 32'(m_tdata[31:16]));
				if (m_tdata[40:32] !== want.occ)
					report("occupancy", 32'(want.occ), 32'(m_tdata[40:32]));
				if (m_tdata[47:41] !== 7'd0)
					report("tdata padding", 32'd0, 32'(m_tdata[47:41]));
			end
			got++;
		end
	end

endmodule
